// ===== hdl/plst_pkg.sv =====
// Shared types and constants for the peer link statistics table.
package plst_pkg;

  typedef enum logic [3:0] {
    K_ADD      = 4'd0,
    K_REMOVE   = 4'd1,
    K_RX       = 4'd2,
    K_ACK      = 4'd3,
    K_SENT     = 4'd4,
    K_FAIL     = 4'd5,
    K_DRVERR   = 4'd6,
    K_LOST     = 4'd7,
    K_RETRY    = 4'd8,
    K_QUERY    = 4'd9,
    K_RESETALL = 4'd10,
    K_FLUSHDONE = 4'd11
  } kind_t;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_MATH, S_DONE} bst_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic signed [7:0] RSSI_NONE = -8'sd127;
  localparam logic [8:0] RTT_WEIGHT = 9'd32;

  localparam logic [2:0] REG_RX = 3'd0;
  localparam logic [2:0] REG_TX = 3'd1;
  localparam logic [2:0] REG_FAIL = 3'd2;
  localparam logic [2:0] REG_DRV = 3'd3;
  localparam logic [2:0] REG_LOST = 3'd4;
  localparam logic [2:0] REG_RTT = 3'd5;

  localparam logic [2:0] CNT_RX = 3'd0;
  localparam logic [2:0] CNT_SENT = 3'd1;
  localparam logic [2:0] CNT_LOST = 3'd2;
  localparam logic [2:0] CNT_FAIL = 3'd3;
  localparam logic [2:0] CNT_DRV = 3'd4;
  localparam logic [2:0] CNT_RETRY = 3'd5;

  // Event as classified by the front end.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  peer;
    logic [7:0]  rssi;
    logic [15:0] rtt;
    logic [7:0]  weight;
  } evt_t;

  function automatic logic [7:0] weight_for(input logic [31:0] hb);
    logic [7:0] w;
    if (hb == 32'd0) w = 8'd51;
    else if (hb < 32'd5000) w = 8'd26;
    else if (hb < 32'd30000) w = 8'd64;
    else w = 8'd102;
    return w;
  endfunction

endpackage

// ===== hdl/peer_link_statistics_table_unit.sv =====
// Top level of the peer link statistics table with its register port.
// Each event passes through four steps in the back end (lookup, arithmetic,
// update, result); a two-entry queue in front accepts events while one is in work.
// The result strobe is high for one cycle and cannot be held off. The back end
// starts the next event only after the last one has finished its result step.
module peer_link_statistics_table_unit import plst_pkg::*; #(
  parameter int PEER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_kind,
  input  logic [7:0]  in_peer_id,
  input  logic [7:0]  in_rssi_sample,
  input  logic [15:0] in_rtt_sample_ms,
  input  logic [31:0] in_heartbeat_ms,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic        out_flush_request,
  output logic [7:0]  out_rssi_last,
  output logic [7:0]  out_rssi_average,
  output logic [15:0] out_rtt_last_ms,
  output logic [15:0] out_rtt_average_ms,
  output logic [31:0] out_received_count,
  output logic [31:0] out_sent_count,
  output logic [31:0] out_lost_count,
  output logic [31:0] out_failure_count,
  output logic [31:0] out_driver_error_count,
  output logic [31:0] out_retry_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] lim_r [6];
  logic q_valid, pop;
  evt_t q_evt;
  logic [2:0] ri;

  assign pready = 1'b1;
  assign ri = paddr[4:2];
  assign prdata = (ri < 3'd6) ? {16'd0, lim_r[ri]} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r[REG_RX] <= 16'd100;
      lim_r[REG_TX] <= 16'd50;
      lim_r[REG_FAIL] <= 16'd10;
      lim_r[REG_DRV] <= 16'd10;
      lim_r[REG_LOST] <= 16'd10;
      lim_r[REG_RTT] <= 16'd50;
    end else if (psel && penable && pwrite && ri < 3'd6) begin
      lim_r[ri] <= pwdata[15:0];
    end
  end

  plst_front u_front (
    .clk, .rst_n, .start, .busy, .in_kind, .in_peer_id, .in_rssi_sample,
    .in_rtt_sample_ms, .in_heartbeat_ms, .pop, .q_valid, .q_evt
  );

  plst_back #(.PEER_SLOTS(PEER_SLOTS)) u_back (
    .clk, .rst_n, .q_valid, .q_evt, .pop, .lim(lim_r), .out_strobe, .out_status,
    .out_flush_request, .out_rssi_last, .out_rssi_average, .out_rtt_last_ms,
    .out_rtt_average_ms, .out_received_count, .out_sent_count, .out_lost_count,
    .out_failure_count, .out_driver_error_count, .out_retry_count
  );

endmodule

// ===== hdl/plst_front.sv =====
// Front end: accepts events, computes the add weight and queues them.
module plst_front import plst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_kind,
  input  logic [7:0]  in_peer_id,
  input  logic [7:0]  in_rssi_sample,
  input  logic [15:0] in_rtt_sample_ms,
  input  logic [31:0] in_heartbeat_ms,
  input  logic        pop,
  output logic        q_valid,
  output evt_t        q_evt
);

  evt_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       push;
  evt_t       e;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_evt = q_r[rd_r];

  always_comb begin
    e.kind = in_kind;
    e.peer = in_peer_id;
    e.rssi = in_rssi_sample;
    e.rtt = in_rtt_sample_ms;
    e.weight = weight_for(in_heartbeat_ms);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt = pop ? !rd_r : rd_r;
    wr_nxt = push ? !wr_r : wr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
    if (push) q_r[wr_r] <= e;
  end

endmodule

// ===== hdl/plst_back.sv =====
// Back end: looks up the peer, updates the entry and emits the result.
module plst_back import plst_pkg::*; #(
  parameter int PEER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  evt_t        q_evt,
  output logic        pop,
  input  logic [15:0] lim [6],
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic        out_flush_request,
  output logic [7:0]  out_rssi_last,
  output logic [7:0]  out_rssi_average,
  output logic [15:0] out_rtt_last_ms,
  output logic [15:0] out_rtt_average_ms,
  output logic [31:0] out_received_count,
  output logic [31:0] out_sent_count,
  output logic [31:0] out_lost_count,
  output logic [31:0] out_failure_count,
  output logic [31:0] out_driver_error_count,
  output logic [31:0] out_retry_count
);

  localparam int SW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

  bst_t st_r, st_nxt;

  logic [PEER_SLOTS-1:0] valid_r;
  logic [7:0]  peer_r [PEER_SLOTS];
  logic [7:0]  wt_r [PEER_SLOTS];
  logic [7:0]  rl_r [PEER_SLOTS];
  logic [7:0]  ra_r [PEER_SLOTS];
  logic [15:0] tl_r [PEER_SLOTS];
  logic [15:0] ta_r [PEER_SLOTS];
  logic [5:0][31:0] cnt_r [PEER_SLOTS];
  logic [5:0][15:0] drt_r [PEER_SLOTS];

  evt_t        ev_r;
  logic        hit_r, free_r;
  logic [SW-1:0] slot_r;
  logic        hit_c, free_c;
  logic [SW-1:0] hslot_c, fslot_c;
  logic [16:0] rprod_r;
  logic [23:0] tprod_r;

  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; hslot_c = '0; fslot_c = '0;
    for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && peer_r[i] == q_evt.peer) begin
        hit_c = 1'b1; hslot_c = SW'(i);
      end
      if (!valid_r[i]) begin
        free_c = 1'b1; fslot_c = SW'(i);
      end
    end
  end

  logic [8:0] s9, a9;
  logic [7:0] w;
  always_comb begin
    w = wt_r[slot_r];
    s9 = {1'b0, ev_r.rssi ^ 8'h80};
    a9 = {1'b0, ra_r[slot_r] ^ 8'h80};
  end

  always_comb begin
    st_nxt = st_r;
    pop = 1'b0;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        pop = 1'b1; st_nxt = S_LOOK;
      end
      S_LOOK: st_nxt = S_MATH;
      S_MATH: st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic [2:0] ci, di;
  logic       bumps, hasc;
  always_comb begin
    ci = CNT_RX; di = REG_RX; bumps = 1'b1; hasc = 1'b1;
    unique case (kind_t'(ev_r.kind))
      K_RX: begin ci = CNT_RX; di = REG_RX; end
      K_ACK: begin hasc = 1'b0; di = REG_RTT; end
      K_SENT: begin ci = CNT_SENT; di = REG_TX; end
      K_FAIL: begin ci = CNT_FAIL; di = REG_FAIL; end
      K_DRVERR: begin ci = CNT_DRV; di = REG_DRV; end
      K_LOST: begin ci = CNT_LOST; di = REG_LOST; end
      K_RETRY: begin ci = CNT_RETRY; di = REG_TX; end
      default: begin bumps = 1'b0; hasc = 1'b0; end
    endcase
  end

  logic over;
  logic [15:0] dnew [6];
  always_comb begin
    over = 1'b0;
    for (int k = 0; k < 6; k++) begin
      dnew[k] = drt_r[slot_r][k];
      if (bumps && di == 3'(k) && dnew[k] != 16'hFFFF) dnew[k] = dnew[k] + 16'd1;
      if (dnew[k] >= lim[k]) over = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      valid_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_strobe <= 1'b0;
      if (st_r == S_IDLE && q_valid) begin
        ev_r <= q_evt;
        hit_r <= hit_c; free_r <= free_c;
        slot_r <= hit_c ? hslot_c : fslot_c;
      end
      if (st_r == S_LOOK) begin
        rprod_r <= 17'((s9 * {1'b0, w} + a9 * (9'd256 - {1'b0, w})) >> 8);
        tprod_r <= 24'((ev_r.rtt * RTT_WEIGHT + ta_r[slot_r] * (9'd256 - RTT_WEIGHT)) >> 8);
        if (kind_t'(ev_r.kind) == K_ADD && !hit_r && free_r) begin
          valid_r[slot_r] <= 1'b1;
          peer_r[slot_r] <= ev_r.peer;
          rl_r[slot_r] <= 8'd0;
          ra_r[slot_r] <= RSSI_NONE;
          tl_r[slot_r] <= 16'd0;
          ta_r[slot_r] <= 16'd0;
          cnt_r[slot_r] <= '0;
          drt_r[slot_r] <= '0;
        end
        if (kind_t'(ev_r.kind) == K_ADD && (hit_r || free_r)) wt_r[slot_r] <= ev_r.weight;
      end
      if (st_r == S_MATH && hit_r && ev_r.kind <= K_QUERY && ev_r.kind != K_ADD) begin
        if (kind_t'(ev_r.kind) == K_REMOVE) valid_r[slot_r] <= 1'b0;
        if (kind_t'(ev_r.kind) == K_RX) begin
          rl_r[slot_r] <= ev_r.rssi;
          ra_r[slot_r] <= (ra_r[slot_r] == RSSI_NONE) ? ev_r.rssi
                          : (rprod_r[7:0] ^ 8'h80);
        end
        if (kind_t'(ev_r.kind) == K_ACK) begin
          tl_r[slot_r] <= ev_r.rtt;
          ta_r[slot_r] <= (ta_r[slot_r] == 16'd0) ? ev_r.rtt : tprod_r[15:0];
        end
        if (hasc) cnt_r[slot_r][ci] <= cnt_r[slot_r][ci] + 32'd1;
        if (bumps) drt_r[slot_r][di] <= dnew[di];
        out_flush_request <= bumps && over;
      end else if (st_r == S_MATH) begin
        out_flush_request <= (kind_t'(ev_r.kind) == K_RESETALL);
      end
      if (st_r == S_MATH && (kind_t'(ev_r.kind) == K_RESETALL ||
                             kind_t'(ev_r.kind) == K_FLUSHDONE)) begin
        for (int i = 0; i < PEER_SLOTS; i++) begin
          drt_r[i] <= '0;
          if (kind_t'(ev_r.kind) == K_RESETALL && valid_r[i]) begin
            cnt_r[i] <= '0;
            rl_r[i] <= 8'd0; ra_r[i] <= RSSI_NONE; tl_r[i] <= 16'd0; ta_r[i] <= 16'd0;
          end
        end
      end
      if (st_r == S_DONE) out_strobe <= 1'b1;
    end
  end

  logic rep;
  always_comb begin
    rep = hit_r && ev_r.kind <= K_QUERY && ev_r.kind != K_REMOVE && ev_r.kind != K_ADD;
    if (kind_t'(ev_r.kind) == K_ADD) rep = hit_r || free_r;
    out_status = ST_OK;
    if (kind_t'(ev_r.kind) == K_ADD && !hit_r && !free_r) out_status = ST_FULL;
    else if (ev_r.kind >= K_REMOVE && ev_r.kind <= K_QUERY && !hit_r) out_status = ST_UNKNOWN;
    out_rssi_last = rep ? rl_r[slot_r] : '0;
    out_rssi_average = rep ? ra_r[slot_r] : '0;
    out_rtt_last_ms = rep ? tl_r[slot_r] : '0;
    out_rtt_average_ms = rep ? ta_r[slot_r] : '0;
    out_received_count = rep ? cnt_r[slot_r][CNT_RX] : '0;
    out_sent_count = rep ? cnt_r[slot_r][CNT_SENT] : '0;
    out_lost_count = rep ? cnt_r[slot_r][CNT_LOST] : '0;
    out_failure_count = rep ? cnt_r[slot_r][CNT_FAIL] : '0;
    out_driver_error_count = rep ? cnt_r[slot_r][CNT_DRV] : '0;
    out_retry_count = rep ? cnt_r[slot_r][CNT_RETRY] : '0;
  end

endmodule
